// ===== design/huffman_tree_walk_decoder_core_defines.svh =====
// Assertion macros shared by the Huffman tree walk decoder RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH

// Concurrent check, switched off while reset is asserted.
`define HTWD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Concurrent check that also holds during reset.
`define HTWD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ===== design/htwd_pkg.sv =====
// Shared types and constants of the Huffman tree walk decoder.
// No dependencies; used by htwd_walker and the top level.
`default_nettype none

package htwd_pkg;

    localparam int IDX_W      = 9;
    localparam int NODE_COUNT = 1 << IDX_W;
    localparam int SYM_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int BIT_W      = 3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic             leaf;
        logic             end_flag;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } kids_t;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  node_index;
        logic              node_is_leaf;
        logic              node_is_end;
        logic [SYM_W-1:0]  node_symbol;
        logic [IDX_W-1:0]  left_index;
        logic [IDX_W-1:0]  right_index;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             end_found;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

// ===== design/huffman_tree_walk_decoder_core.sv =====
// A data byte is accepted in the idle state; the walk then reads one node table entry
// per consumed bit (up to 8) and releases the final result of the byte, which shows on
// m_tvalid once it is in the output register. The children of the current node are
// fetched first when they are not cached at byte start, as are the root's after a leaf.
// A new data byte is taken only once the previous one is through, as each bit needs a
// node table read. Synchronous reset clears root, walk, end flag and valid flags, not the table.
`default_nettype none

module huffman_tree_walk_decoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream. A transaction with tuser = 0 loads one tree node, with
    // tuser = 1 it delivers one compressed byte.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, lowest bit up: node_index[8:0], node_is_leaf[9], node_is_end[10],
    // node_symbol[18:11], left_index[27:19], right_index[36:28], data_byte[44:37],
    // zero fill [47:45].
    input  wire logic [47:0] s_tdata,
    // s_tuser: kind.
    input  wire logic        s_tuser,
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: symbol[7:0].
    output logic [7:0]       m_tdata,
    // m_tuser: end_found.
    output logic             m_tuser,
    output logic             m_tlast,
    // Configuration: root_index.
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data
);

    // The incoming transaction is unpacked into the item structure used by the
    // walker. Field positions follow the packing listed beside s_tdata.
    htwd_pkg::item_t   item;
    htwd_pkg::result_t push;
    logic              out_free;

    logic                       m_valid_reg;
    logic [htwd_pkg::SYM_W-1:0] m_symbol_reg;
    logic                       m_end_reg;
    logic                       m_last_reg;

    assign item.kind         = s_tuser;
    assign item.node_index   = s_tdata[8:0];
    assign item.node_is_leaf = s_tdata[9];
    assign item.node_is_end  = s_tdata[10];
    assign item.node_symbol  = s_tdata[18:11];
    assign item.left_index   = s_tdata[27:19];
    assign item.right_index  = s_tdata[36:28];
    assign item.data_byte    = s_tdata[44:37];

    // The walker keeps the node table, the walk position and the root register.
    // It holds the most recent result back until it knows whether another one
    // follows from the same byte, so that tlast can be set on the final one.
    htwd_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_tvalid),
        .item        (item),
        .item_ready  (s_tready),
        .out_free    (out_free),
        .push        (push),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Output register. It separates the walker from the downstream handshake:
    // the walker may accept the next byte while a result is still waiting here,
    // and a new result is loaded in the same cycle that the old one is taken.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            m_symbol_reg <= push.symbol;
            m_end_reg    <= push.end_found;
            m_last_reg   <= push.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_symbol_reg;
    assign m_tuser  = m_end_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== design/htwd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds its value in cycles without a read. No dependencies.
`default_nettype none

module htwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/htwd_walker.sv =====
// Tree walk sequencer: node table, walk position, root register and result ordering.
// Depends on htwd_pkg, htwd_ram and the shared assertion macros.
`default_nettype none
`include "huffman_tree_walk_decoder_core_defines.svh"

module htwd_walker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         item_valid,
    input  wire htwd_pkg::item_t              item,
    output logic                              item_ready,
    input  wire logic                         out_free,
    output htwd_pkg::result_t                 push,
    input  wire logic                         cfg_wr_en,
    input  wire logic [htwd_pkg::IDX_W-1:0]   cfg_wr_data
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_FETCH      = 3'd1;
    localparam logic [2:0] ST_FETCH_WAIT = 3'd2;
    localparam logic [2:0] ST_START      = 3'd3;
    localparam logic [2:0] ST_WALK       = 3'd4;
    localparam logic [2:0] ST_FLUSH      = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [htwd_pkg::IDX_W-1:0]    root_reg, root_next;
    logic [htwd_pkg::IDX_W-1:0]    walk_reg, walk_next;
    htwd_pkg::kids_t               kids_reg, kids_next;
    logic                          kids_valid_reg, kids_valid_next;
    htwd_pkg::kids_t               root_kids_reg, root_kids_next;
    logic                          root_kids_valid_reg, root_kids_valid_next;
    logic                          done_reg, done_next;
    logic [htwd_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic [htwd_pkg::BIT_W-1:0]    bit_reg, bit_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [htwd_pkg::SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                          pend_end_reg, pend_end_next;

    logic                          ram_we;
    logic [htwd_pkg::IDX_W-1:0]    ram_waddr;
    htwd_pkg::node_t               ram_wnode;
    logic                          ram_re;
    logic [htwd_pkg::IDX_W-1:0]    ram_raddr;
    logic [htwd_pkg::NODE_W-1:0]   ram_rdata;
    htwd_pkg::node_t               rd_node;
    logic [htwd_pkg::BIT_W-1:0]    bit_dec;
    logic                          next_bit;
    logic                          hit;
    htwd_pkg::kids_t               load_kids;

    htwd_ram #(
        .WIDTH (htwd_pkg::NODE_W),
        .DEPTH (htwd_pkg::NODE_COUNT)
    ) u_node_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wnode),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_node   = htwd_pkg::node_t'(ram_rdata);
    assign bit_dec   = bit_reg - 1'b1;
    assign next_bit  = byte_reg[bit_dec];
    assign hit       = rd_node.leaf | rd_node.end_flag;
    assign load_kids = '{left: item.left_index, right: item.right_index};

    // Writes happen only in the idle state and reads never do, so the table
    // needs no read-during-write forwarding.
    always_comb begin
        state_next           = state_reg;
        root_next            = root_reg;
        walk_next            = walk_reg;
        kids_next            = kids_reg;
        kids_valid_next      = kids_valid_reg;
        root_kids_next       = root_kids_reg;
        root_kids_valid_next = root_kids_valid_reg;
        done_next            = done_reg;
        byte_next            = byte_reg;
        bit_next             = bit_reg;
        pend_valid_next      = pend_valid_reg;
        pend_sym_next        = pend_sym_reg;
        pend_end_next        = pend_end_reg;
        ram_we               = 1'b0;
        ram_waddr            = item.node_index;
        ram_wnode            = '{leaf:     item.node_is_leaf,
                                 end_flag: item.node_is_end,
                                 symbol:   item.node_symbol,
                                 left:     item.left_index,
                                 right:    item.right_index};
        ram_re               = 1'b0;
        ram_raddr            = walk_reg;
        push                 = '0;
        item_ready           = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    if (item.kind == htwd_pkg::KIND_LOAD) begin
                        ram_we    = 1'b1;
                        done_next = 1'b0;
                        walk_next = root_reg;
                        if (item.node_index == root_reg) begin
                            root_kids_next       = load_kids;
                            root_kids_valid_next = 1'b1;
                        end
                        kids_next       = root_kids_next;
                        kids_valid_next = root_kids_valid_next;
                    end else if (!done_reg) begin
                        byte_next  = item.data_byte;
                        bit_next   = '1;
                        state_next = kids_valid_reg ? ST_START : ST_FETCH;
                    end
                end
                if (cfg_wr_en) begin
                    root_next            = cfg_wr_data;
                    walk_next            = cfg_wr_data;
                    kids_valid_next      = 1'b0;
                    root_kids_valid_next = 1'b0;
                end
            end
            ST_FETCH: begin
                ram_re     = 1'b1;
                ram_raddr  = walk_reg;
                state_next = ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT: begin
                kids_next       = '{left: rd_node.left, right: rd_node.right};
                kids_valid_next = 1'b1;
                if (walk_reg == root_reg) begin
                    root_kids_next       = kids_next;
                    root_kids_valid_next = 1'b1;
                end
                state_next = ST_START;
            end
            ST_START: begin
                ram_re     = 1'b1;
                ram_raddr  = byte_reg[bit_reg] ? kids_reg.right : kids_reg.left;
                walk_next  = ram_raddr;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                // A new result with one already waiting needs room downstream.
                if (!(hit && pend_valid_reg && !out_free)) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            push = '{valid: 1'b1, symbol: pend_sym_reg,
                                     end_found: pend_end_reg, last: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = rd_node.leaf ? rd_node.symbol : '0;
                        pend_end_next   = !rd_node.leaf;
                        walk_next       = root_reg;
                    end
                    if (rd_node.leaf) begin
                        if (bit_reg == '0) begin
                            kids_next       = root_kids_reg;
                            kids_valid_next = root_kids_valid_reg;
                            state_next      = ST_FLUSH;
                        end else if (root_kids_valid_reg) begin
                            bit_next  = bit_dec;
                            ram_re    = 1'b1;
                            ram_raddr = next_bit ? root_kids_reg.right : root_kids_reg.left;
                            walk_next = ram_raddr;
                        end else begin
                            bit_next        = bit_dec;
                            kids_valid_next = 1'b0;
                            state_next      = ST_FETCH;
                        end
                    end else if (rd_node.end_flag) begin
                        done_next       = 1'b1;
                        kids_next       = root_kids_reg;
                        kids_valid_next = root_kids_valid_reg;
                        state_next      = ST_FLUSH;
                    end else if (bit_reg == '0) begin
                        kids_next       = '{left: rd_node.left, right: rd_node.right};
                        kids_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end else begin
                        bit_next  = bit_dec;
                        ram_re    = 1'b1;
                        ram_raddr = next_bit ? rd_node.right : rd_node.left;
                        walk_next = ram_raddr;
                    end
                end
            end
            ST_FLUSH: begin
                if (pend_valid_reg) begin
                    if (out_free) begin
                        push = '{valid: 1'b1, symbol: pend_sym_reg,
                                 end_found: pend_end_reg, last: 1'b1};
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            root_reg            <= '0;
            walk_reg            <= '0;
            kids_valid_reg      <= 1'b0;
            root_kids_valid_reg <= 1'b0;
            done_reg            <= 1'b0;
            pend_valid_reg      <= 1'b0;
        end else begin
            state_reg           <= state_next;
            root_reg            <= root_next;
            walk_reg            <= walk_next;
            kids_valid_reg      <= kids_valid_next;
            root_kids_valid_reg <= root_kids_valid_next;
            done_reg            <= done_next;
            pend_valid_reg      <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kids_reg      <= kids_next;
        root_kids_reg <= root_kids_next;
        byte_reg      <= byte_next;
        bit_reg       <= bit_next;
        pend_sym_reg  <= pend_sym_next;
        pend_end_reg  <= pend_end_next;
    end

    `HTWD_ASSERT_RST(a_push_has_room, push.valid |-> out_free,
        "result pushed while the output register is full")
    `HTWD_ASSERT_RST(a_end_is_pending, $rose(done_reg) |-> (pend_valid_reg && pend_end_reg
        && state_reg == ST_FLUSH), "end of stream reached without a pending end marker")
    `HTWD_ASSERT_RST(a_start_has_kids, (state_reg == ST_START) |-> kids_valid_reg,
        "walk step started without the children of the current node")
    `HTWD_ASSERT_ALWAYS(a_no_table_overlap, !(ram_we && ram_re),
        "node table written and read in the same cycle")

endmodule

`default_nettype wire

// ===== tb/sv/tb_huffman_tree_walk_decoder_core.sv =====
// Self-checking testbench for the Huffman tree walk decoder core.
// Depends on htwd_pkg and huffman_tree_walk_decoder_core with its submodules.
`timescale 1ns / 1ps

module tb_huffman_tree_walk_decoder_core;

    // Random transactions that do real work, and the point after which
    // both sides stop idling so the run ends at full rate.
    localparam int RANDOM_ITEMS   = 150;
    localparam int CALM_AFTER     = 120;
    // A byte that yields no symbol can still be walking when the last
    // expected result shows up, so set_root waits for that walk to end.
    localparam int SETTLE_CYCLES  = 20;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PACE [3]       = '{0, 15, 50};

    typedef struct packed {
        bit [7:0] symbol;
        bit       end_found;
        bit       last;
    } dec_t;

    localparam dec_t END_MARK  = '{symbol: 8'h00, end_found: 1'b1, last: 1'b1};
    localparam dec_t NO_RESULT = '{symbol: 8'h00, end_found: 1'b0, last: 1'b0};

    typedef enum bit {ROW_ITEM, ROW_ROOT} row_op_e;

    // One row of the directed plan: either a stream transaction or a write of
    // the root register. A row marked fixed carries its own answer (none or
    // exactly one result) instead of the one the decoder mirror works out.
    typedef struct {
        row_op_e         op;
        htwd_pkg::item_t it;
        bit [8:0]        root;
        bit              fixed;
        bit              one_result;
        dec_t            want;
    } row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [8:0]  cfg_wr_data = '0;

    huffman_tree_walk_decoder_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Mirror of the decoder: node table, root register, walk position and the
    // end-of-stream flag, updated at the edge where each transaction is taken.
    htwd_pkg::node_t tree_mirror [htwd_pkg::NODE_COUNT];
    bit [8:0] root_sel  = '0;
    bit [8:0] walk_at   = '0;
    bit       end_seen  = 1'b0;
    dec_t     step_results [$];
    dec_t     pending_symbols [$];

    // Slots written so far. Every written node points only at written nodes,
    // so no walk can ever land on a slot that holds nothing.
    bit       written [htwd_pkg::NODE_COUNT];
    bit [8:0] written_slots [$];
    bit       taken [htwd_pkg::NODE_COUNT];

    int mismatches   = 0;
    int work_items   = 0;
    int tx_gap_pct   = 15;
    int rx_stall_pct = 15;
    bit calm         = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Works out the results of one accepted input transaction.
    function automatic void decode_item(htwd_pkg::item_t it);
        htwd_pkg::node_t cur;
        htwd_pkg::node_t nx;
        step_results.delete();
        if (it.kind == htwd_pkg::KIND_LOAD) begin
            tree_mirror[it.node_index] = {it.node_is_leaf, it.node_is_end, it.node_symbol,
                                          it.left_index, it.right_index};
            end_seen = 1'b0;
            walk_at  = root_sel;
            return;
        end
        if (end_seen) return;
        for (int b = 7; b >= 0; b--) begin
            cur     = tree_mirror[walk_at];
            walk_at = it.data_byte[b] ? cur.right : cur.left;
            nx      = tree_mirror[walk_at];
            // A node with both flags counts as a symbol leaf.
            if (nx.leaf) begin
                step_results.push_back('{symbol: nx.symbol, end_found: 1'b0, last: 1'b0});
                walk_at = root_sel;
            end else if (nx.end_flag) begin
                // The rest of the byte is thrown away.
                step_results.push_back('{symbol: 8'h00, end_found: 1'b1, last: 1'b0});
                end_seen = 1'b1;
                walk_at  = root_sel;
                break;
            end
        end
        if (step_results.size() > 0) step_results[$].last = 1'b1;
    endfunction

    function automatic htwd_pkg::item_t node_load(bit [8:0] idx, bit is_leaf, bit is_end,
                                                  bit [7:0] sym, bit [8:0] lft,
                                                  bit [8:0] rgt);
        htwd_pkg::item_t it;
        it.kind         = htwd_pkg::KIND_LOAD;
        it.node_index   = idx;
        it.node_is_leaf = is_leaf;
        it.node_is_end  = is_end;
        it.node_symbol  = sym;
        it.left_index   = lft;
        it.right_index  = rgt;
        it.data_byte    = 8'($urandom);
        return it;
    endfunction

    // Node fields are ignored on a data transaction, so they carry noise.
    function automatic htwd_pkg::item_t data_item(bit [7:0] byte_in);
        htwd_pkg::item_t it;
        it           = node_load(9'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                                 9'($urandom), 9'($urandom));
        it.kind      = htwd_pkg::KIND_DATA;
        it.data_byte = byte_in;
        return it;
    endfunction

    function automatic row_t row_plain(htwd_pkg::item_t it);
        row_t row;
        row.op    = ROW_ITEM;
        row.it    = it;
        row.fixed = 1'b0;
        return row;
    endfunction

    function automatic row_t row_fixed(htwd_pkg::item_t it, bit one_result, dec_t want);
        row_t row;
        row            = row_plain(it);
        row.fixed      = 1'b1;
        row.one_result = one_result;
        row.want       = want;
        return row;
    endfunction

    function automatic row_t row_root(bit [8:0] value);
        row_t row;
        row.op   = ROW_ROOT;
        row.root = value;
        return row;
    endfunction

    function automatic bit [8:0] pick_written();
        return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    function automatic bit [8:0] fresh_slot();
        bit [8:0] slot;
        do slot = 9'($urandom_range(0, htwd_pkg::NODE_COUNT - 1)); while (taken[slot]);
        taken[slot] = 1'b1;
        return slot;
    endfunction

    // Offers one input transaction, with an optional idle burst in front, and
    // books its expected results once the handshake completes.
    task automatic send_item(input htwd_pkg::item_t it, input bit fixed, input bit one_result,
                             input dec_t want);
        bit skipped;
        if (!calm && tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b000, it.data_byte, it.right_index, it.left_index, it.node_symbol,
                     it.node_is_end, it.node_is_leaf, it.node_index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        skipped = (it.kind == htwd_pkg::KIND_DATA) && end_seen;
        decode_item(it);
        if (!fixed) begin
            pending_symbols = {pending_symbols, step_results};
        end else if (one_result) begin
            pending_symbols.push_back(want);
        end
        if (it.kind == htwd_pkg::KIND_LOAD && !written[it.node_index]) begin
            written[it.node_index] = 1'b1;
            written_slots.push_back(it.node_index);
        end
        if (!skipped) work_items++;
    endtask

    // The root register may only change while the core is idle: the sender
    // stops, every booked result is drained, then the last walk gets time to end.
    task automatic set_root(input bit [8:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        root_sel = value;
        walk_at  = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: m_tready drops in random bursts.
    initial begin
        forever begin
            @(negedge aclk);
            if (!calm && rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Every result transaction is checked against the oldest booked result.
    always @(posedge aclk) begin
        dec_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_symbols.size() == 0) begin
                $error("unexpected result: symbol %0h end_found %0b last %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                head = pending_symbols.pop_front();
                if (m_tdata !== head.symbol) begin
                    $error("symbol: expected %0h, got %0h", head.symbol, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== head.end_found) begin
                    $error("end_found: expected %0b, got %0b", head.end_found, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== head.last) begin
                    $error("last: expected %0b, got %0b", head.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction has moved for too long.
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $error("timeout with %0d results outstanding", pending_symbols.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        row_t     plan [$];
        bit [8:0] forest [$];
        bit [8:0] slot;
        bit [8:0] lft;
        bit [8:0] rgt;
        bit       use_cfg;
        int       n_leaves;
        int       n_bytes;
        int       a;

        // Directed tree at root 0: code 0 is symbol 00, 10 is symbol FF,
        // 11 is the end of stream. Leaves are written before their parents.
        plan.push_back(row_fixed(node_load(9'd1, 1'b1, 1'b0, 8'h00, 9'd1, 9'd1), 0, NO_RESULT));
        plan.push_back(row_fixed(node_load(9'd3, 1'b1, 1'b0, 8'hFF, 9'd3, 9'd3), 0, NO_RESULT));
        plan.push_back(row_fixed(node_load(9'd511, 1'b0, 1'b1, 8'hA5, 9'd511, 9'd511), 0,
                                 NO_RESULT));
        plan.push_back(row_fixed(node_load(9'd2, 1'b0, 1'b0, 8'h5A, 9'd3, 9'd511), 0, NO_RESULT));
        plan.push_back(row_fixed(node_load(9'd0, 1'b0, 1'b0, 8'hC3, 9'd1, 9'd2), 0, NO_RESULT));
        // Eight symbols from one byte, then four from alternating bits.
        plan.push_back(row_plain(data_item(8'h00)));
        plan.push_back(row_plain(data_item(8'hAA)));
        // End code right away; later bytes are dropped until a node load.
        plan.push_back(row_fixed(data_item(8'hC0), 1, END_MARK));
        plan.push_back(row_fixed(data_item(8'hFF), 0, NO_RESULT));
        plan.push_back(row_fixed(data_item(8'h00), 0, NO_RESULT));
        // A node with both flags decodes as a symbol leaf.
        plan.push_back(row_fixed(node_load(9'd4, 1'b1, 1'b1, 8'h3C, 9'd0, 9'd4), 0, NO_RESULT));
        plan.push_back(row_fixed(node_load(9'd2, 1'b0, 1'b0, 8'h00, 9'd4, 9'd511), 0, NO_RESULT));
        plan.push_back(row_plain(data_item(8'h80)));
        // Symbols, then the end code, with the rest of the byte thrown away.
        plan.push_back(row_plain(data_item(8'h5B)));
        // Root at the top slot, which is the end node itself.
        plan.push_back(row_root(9'd511));
        plan.push_back(row_fixed(node_load(9'd5, 1'b0, 1'b0, 8'h77, 9'd5, 9'd5), 0, NO_RESULT));
        plan.push_back(row_fixed(data_item(8'h3A), 1, END_MARK));
        // Root on a leaf: the root is never tested, only its children.
        plan.push_back(row_root(9'd1));
        plan.push_back(row_fixed(node_load(9'd6, 1'b0, 1'b0, 8'h81, 9'd6, 9'd6), 0, NO_RESULT));
        plan.push_back(row_plain(data_item(8'h96)));
        // Root on a node that loops to itself: a byte with no symbol at all.
        plan.push_back(row_root(9'd5));
        plan.push_back(row_fixed(data_item(8'hE7), 0, NO_RESULT));
        plan.push_back(row_fixed(data_item(8'h18), 0, NO_RESULT));
        plan.push_back(row_root(9'd0));
        plan.push_back(row_plain(data_item(8'h7F)));

        // Synchronous reset, released on a falling edge.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].op == ROW_ROOT) begin
                set_root(plan[k].root);
            end else begin
                send_item(plan[k].it, plan[k].fixed, plan[k].one_result, plan[k].want);
            end
        end

        // Random phases: each builds a fresh random code tree bottom-up, points
        // the walk at it, and streams random bytes through it with an
        // occasional stray node load that breaks the current code.
        work_items = 0;
        while (work_items < RANDOM_ITEMS) begin
            tx_gap_pct   = PACE[$urandom_range(0, 2)];
            rx_stall_pct = PACE[$urandom_range(0, 2)];
            use_cfg      = 1'($urandom_range(0, 1));
            taken        = '{default: 1'b0};
            // Without a register write, the new tree is built under the
            // current root slot, which is written last.
            if (!use_cfg) taken[root_sel] = 1'b1;
            n_leaves = $urandom_range(2, 9);
            forest.delete();
            for (int i = 0; i < n_leaves; i++) begin
                slot = fresh_slot();
                if (i == 0 && $urandom_range(0, 1)) begin
                    send_item(node_load(slot, 1'b0, 1'b1, 8'($urandom), pick_written(),
                                        pick_written()), 0, 0, NO_RESULT);
                end else begin
                    send_item(node_load(slot, 1'b1, $urandom_range(0, 7) == 0, 8'($urandom),
                                        pick_written(), pick_written()), 0, 0, NO_RESULT);
                end
                forest.push_back(slot);
            end
            while (forest.size() > 1) begin
                a   = $urandom_range(0, forest.size() - 1);
                lft = forest[a];
                forest.delete(a);
                a   = $urandom_range(0, forest.size() - 1);
                rgt = forest[a];
                forest.delete(a);
                slot = (forest.size() == 0 && !use_cfg) ? root_sel : fresh_slot();
                send_item(node_load(slot, 1'b0, 1'b0, 8'($urandom), lft, rgt), 0, 0,
                          NO_RESULT);
                forest.push_back(slot);
            end
            if (use_cfg) set_root(forest[0]);

            n_bytes = $urandom_range(3, 12);
            for (int i = 0; i < n_bytes; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(node_load(9'($urandom), 1'($urandom), 1'($urandom),
                                        8'($urandom), pick_written(), pick_written()),
                              0, 0, NO_RESULT);
                end else begin
                    send_item(data_item(8'($urandom)), 0, 0, NO_RESULT);
                end
            end
            if (work_items >= CALM_AFTER) calm = 1'b1;
        end

        // Drain: the sender stops, the booked results come back, then a short
        // tail catches anything extra the core might still emit.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
